FILE: rtl/lbps_pkg.sv
// Shared types and constants of the LED blink pattern sequencer.
// Command codes, default sizes, and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package lbps_pkg;

  localparam int unsigned LBPS_LED_COUNT = 3;
  localparam int unsigned LBPS_TICK_MS   = 10;

  localparam logic [1:0] FUNC_START     = 2'd0;
  localparam logic [1:0] FUNC_TICK      = 2'd1;
  localparam logic [1:0] FUNC_RESET_ONE = 2'd2;
  localparam logic [1:0] FUNC_RESET_ALL = 2'd3;

  localparam logic [8:0] MAX_REPEATS = 9'd256;

  typedef struct packed {
    logic capture;
    logic do_start;
    logic do_adv;
    logic do_upd;
    logic do_clear;
    logic load_out;
  } lbps_cmd_t;

  typedef struct packed {
    logic ptr_last;
  } lbps_sts_t;

endpackage

`default_nettype wire

FILE: rtl/lbps_ctrl.sv
// Controller state machine of the LED blink pattern sequencer.
// Sequences request capture, execution, per-LED tick steps and result load.
// Depends on lbps_pkg.
`default_nettype none

module lbps_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        func_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lbps_pkg::lbps_cmd_t    cmd_o,
  input  wire lbps_pkg::lbps_sts_t sts_i
);
  import lbps_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ADV   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          unique case (func_i) inside
            FUNC_START: state_d = S_START;
            FUNC_TICK:  state_d = S_ADV;
            FUNC_RESET_ONE, FUNC_RESET_ALL: state_d = S_CLEAR;
            default:    state_d = S_CLEAR;
          endcase
        end
      end
      S_START: begin
        cmd_o.do_start = 1'b1;
        state_d        = S_DONE;
      end
      S_ADV: begin
        cmd_o.do_adv = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        cmd_o.do_upd = 1'b1;
        state_d      = sts_i.ptr_last ? S_DONE : S_ADV;
      end
      S_CLEAR: begin
        cmd_o.do_clear = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("request accepted but controller stayed idle");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.do_start, cmd_o.do_adv, cmd_o.do_upd, cmd_o.do_clear, cmd_o.load_out}))
    else $error("more than one datapath action in a cycle");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

  a_done_loads_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> out_valid_q)
    else $error("free output register not loaded");
`endif

endmodule

`default_nettype wire

FILE: rtl/lbps_datapath.sv
// Datapath of the LED blink pattern sequencer: per-LED pattern state,
// start/tick/reset update logic, polarity register and result register.
// Depends on lbps_pkg; driven by lbps_ctrl.
`default_nettype none

module lbps_datapath #(
  parameter int unsigned LED_COUNT = lbps_pkg::LBPS_LED_COUNT,
  parameter int unsigned TICK_MS   = lbps_pkg::LBPS_TICK_MS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [7:0]          cfg_wdata_i,
  input  wire logic [1:0]          func_i,
  input  wire logic [2:0]          led_sel_i,
  input  wire logic [15:0]         on_time_ms_i,
  input  wire logic [15:0]         off_time_ms_i,
  input  wire logic [7:0]          repeat_count_i,
  input  wire logic                steady_i,
  input  wire logic [7:0]          priority_req_i,
  input  wire lbps_pkg::lbps_cmd_t cmd_i,
  output lbps_pkg::lbps_sts_t      sts_o,
  output logic                     rejected_o,
  output logic [7:0]               pin_levels_o,
  output logic [7:0]               lit_mask_o,
  output logic [7:0]               busy_mask_o,
  output logic                     any_busy_o
);
  import lbps_pkg::*;

  localparam int unsigned IdxW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [31:0] TickInc = 32'(TICK_MS);
  localparam logic [IdxW-1:0] LastLed = IdxW'(LED_COUNT - 1);

  logic [23:0]          on_dur_q   [LED_COUNT];
  logic [23:0]          off_dur_q  [LED_COUNT];
  logic [8:0]           rep_q      [LED_COUNT];
  logic [7:0]           prio_q     [LED_COUNT];
  logic [31:0]          elapsed_q  [LED_COUNT];
  logic [31:0]          phase_q    [LED_COUNT];
  logic [LED_COUNT-1:0] lit_q;
  logic [LED_COUNT-1:0] steady_q;
  logic [7:0]           mask_q;
  logic [IdxW-1:0]      ptr_q;
  logic                 rejected_q;

  logic [1:0]  func_q;
  logic [2:0]  idx_q;
  logic        in_range_q;
  logic [15:0] on_q;
  logic [15:0] off_q;
  logic [7:0]  rcnt_q;
  logic        st_q;
  logic [7:0]  preq_q;

  logic [7:0] pins_q, litm_q, busy_q;
  logic       anyb_q, rej_out_q;

  logic [IdxW-1:0] sel;
  logic            rep_nz;
  logic            reject;
  logic            on_zero, off_zero;
  logic [15:0]     mul_a;
  logic [23:0]     prod;
  logic [23:0]     st_on_d, st_off_d;
  logic [8:0]      st_rep_d;
  logic [31:0]     span;
  logic [31:0]     phase_add;
  logic [8:0]      tk_rep_d;
  logic            tk_lit_d;
  logic [31:0]     tk_phase_d;
  logic [7:0]      pins_d, litm_d, busy_d;

  assign sel            = (cmd_i.do_adv || cmd_i.do_upd) ? ptr_q : idx_q[IdxW-1:0];
  assign rep_nz         = (rep_q[sel] != 9'd0);
  assign sts_o.ptr_last = (ptr_q == LastLed);

  // Start: steady clears repeats; fold zero phases; add a compensating repeat to a lit LED with more than one repeat
  assign reject   = rep_nz && (prio_q[sel] > preq_q);
  assign on_zero  = (on_q == 16'd0);
  assign off_zero = (off_q == 16'd0);
  assign mul_a    = on_zero ? off_q : on_q;
  assign prod     = {8'd0, mul_a} * {16'd0, rcnt_q};

  always_comb begin
    st_on_d  = {8'd0, on_q};
    st_off_d = {8'd0, off_q};
    st_rep_d = {1'b0, rcnt_q};
    if (st_q) begin
      st_rep_d = 9'd0;
    end else if (on_zero) begin
      st_off_d = prod;
      st_rep_d = 9'd1;
    end else if (off_zero) begin
      st_on_d  = prod;
      st_rep_d = 9'd1;
    end else if (lit_q[sel] && rcnt_q > 8'd1) begin
      st_rep_d = {1'b0, rcnt_q} + 9'd1;
    end
  end

  // Tick: end the current phase once its span is exceeded
  assign span      = elapsed_q[sel] - phase_q[sel];
  assign phase_add = phase_q[sel] + {8'd0, (lit_q[sel] ? on_dur_q[sel] : off_dur_q[sel])};

  always_comb begin
    tk_rep_d   = rep_q[sel];
    tk_lit_d   = lit_q[sel];
    tk_phase_d = phase_q[sel];
    if (lit_q[sel]) begin
      if (span > {8'd0, on_dur_q[sel]}) begin
        tk_lit_d = 1'b0;
        if (off_dur_q[sel] != 24'd0) begin
          tk_phase_d = phase_add;
        end else begin
          tk_rep_d = 9'd0;
        end
      end
    end else if (span > {8'd0, off_dur_q[sel]}) begin
      tk_rep_d = rep_q[sel] - 9'd1;
      if (tk_rep_d != 9'd0) begin
        tk_lit_d   = 1'b1;
        tk_phase_d = phase_add;
      end
    end
    if (tk_rep_d == 9'd0) begin
      tk_lit_d = 1'b0;
    end
  end

  always_comb begin
    pins_d = '0;
    litm_d = '0;
    busy_d = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < LED_COUNT) begin
        litm_d[i] = lit_q[i];
        pins_d[i] = lit_q[i] ? mask_q[i] : !mask_q[i];
        busy_d[i] = (rep_q[i] != 9'd0) || steady_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q     <= func_i;
      idx_q      <= led_sel_i;
      in_range_q <= (int'(led_sel_i) < LED_COUNT);
      on_q       <= on_time_ms_i;
      off_q      <= off_time_ms_i;
      rcnt_q     <= repeat_count_i;
      st_q       <= steady_i;
      preq_q     <= priority_req_i;
    end
    if (cmd_i.load_out) begin
      rej_out_q <= rejected_q;
      pins_q    <= pins_d;
      litm_q    <= litm_d;
      busy_q    <= busy_d;
      anyb_q    <= (busy_d != 8'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        on_dur_q[i]  <= '0;
        off_dur_q[i] <= '0;
        rep_q[i]     <= '0;
        prio_q[i]    <= '0;
        elapsed_q[i] <= '0;
        phase_q[i]   <= '0;
      end
      lit_q      <= '0;
      steady_q   <= '0;
      mask_q     <= '0;
      ptr_q      <= '0;
      rejected_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        rejected_q <= 1'b0;
        ptr_q      <= '0;
      end
      if (cmd_i.do_start && in_range_q) begin
        if (reject) begin
          rejected_q <= 1'b1;
        end else begin
          prio_q[sel]    <= preq_q;
          steady_q[sel]  <= st_q && !on_zero;
          on_dur_q[sel]  <= st_on_d;
          off_dur_q[sel] <= st_off_d;
          rep_q[sel]     <= st_rep_d;
          elapsed_q[sel] <= '0;
          phase_q[sel]   <= '0;
          lit_q[sel]     <= (st_on_d != 24'd0);
        end
      end
      if (cmd_i.do_adv && rep_nz) begin
        elapsed_q[sel] <= elapsed_q[sel] + TickInc;
      end
      if (cmd_i.do_upd) begin
        if (rep_nz) begin
          rep_q[sel]   <= tk_rep_d;
          lit_q[sel]   <= tk_lit_d;
          phase_q[sel] <= tk_phase_d;
        end
        if (!sts_o.ptr_last) begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
      if (cmd_i.do_clear) begin
        if (func_q == FUNC_RESET_ALL) begin
          for (int i = 0; i < LED_COUNT; i++) begin
            rep_q[i]  <= '0;
            prio_q[i] <= '0;
          end
        end else if (in_range_q) begin
          rep_q[sel]  <= '0;
          prio_q[sel] <= '0;
          lit_q[sel]  <= 1'b0;
        end
      end
    end
  end

  assign rejected_o   = rej_out_q;
  assign pin_levels_o = pins_q;
  assign lit_mask_o   = litm_q;
  assign busy_mask_o  = busy_q;
  assign any_busy_o   = anyb_q;

`ifndef SYNTHESIS
  a_rep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q[ptr_q] <= MAX_REPEATS)
    else $error("repeat count beyond compensated maximum");

  a_reject_only_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rejected_q |-> func_q == FUNC_START)
    else $error("reject flag set by a request other than start");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(ptr_q) < LED_COUNT)
    else $error("tick pointer past last LED");
`endif

endmodule

`default_nettype wire

FILE: rtl/led_blink_pattern_sequencer_core.sv
// Top level of the LED blink pattern sequencer.
// Instantiates lbps_ctrl and lbps_datapath; depends on lbps_pkg.
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid_i / in_stall_o   func, LED select, times, repeats, flags
//   out      from block out_valid_o / out_stall_i rejected, pin levels, lit, busy
//   cfg      to block   cfg_we_i                  on_level_mask (cfg_wdata_i)
//
// Start and reset requests run one START or CLEAR state before DONE loads the result.
// A tick runs ADV then UPD for each LED before DONE loads its result; one shared
// elapsed/phase unit steps through the LEDs.
// One request is in flight at a time; the next is accepted in the cycle after the load.
// A held result stalls only the final load.
// Reset clears all pattern state, the polarity mask and the result valid flag.
`default_nettype none

module led_blink_pattern_sequencer_core #(
  parameter int unsigned LED_COUNT = lbps_pkg::LBPS_LED_COUNT,
  parameter int unsigned TICK_MS   = lbps_pkg::LBPS_TICK_MS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [2:0]  led_sel_i,
  input  wire logic [15:0] on_time_ms_i,
  input  wire logic [15:0] off_time_ms_i,
  input  wire logic [7:0]  repeat_count_i,
  input  wire logic        steady_i,
  input  wire logic [7:0]  priority_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             rejected_o,
  output logic [7:0]       pin_levels_o,
  output logic [7:0]       lit_mask_o,
  output logic [7:0]       busy_mask_o,
  output logic             any_busy_o
);
  import lbps_pkg::*;

  lbps_cmd_t cmd;
  lbps_sts_t sts;

  lbps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lbps_datapath #(
    .LED_COUNT (LED_COUNT),
    .TICK_MS   (TICK_MS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .func_i         (func_i),
    .led_sel_i      (led_sel_i),
    .on_time_ms_i   (on_time_ms_i),
    .off_time_ms_i  (off_time_ms_i),
    .repeat_count_i (repeat_count_i),
    .steady_i       (steady_i),
    .priority_req_i (priority_req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rejected_o     (rejected_o),
    .pin_levels_o   (pin_levels_o),
    .lit_mask_o     (lit_mask_o),
    .busy_mask_o    (busy_mask_o),
    .any_busy_o     (any_busy_o)
  );

endmodule

`default_nettype wire
